// File: hdl/cle_pkg.sv
`timescale 1ns / 1ps

package cle_pkg;

    localparam logic [7:0] ASCII_BS  = 8'h08;
    localparam logic [7:0] ASCII_LF  = 8'h0A;
    localparam logic [7:0] ASCII_CR  = 8'h0D;
    localparam logic [7:0] ASCII_SP  = 8'h20;
    localparam logic [7:0] ASCII_GT  = 8'h3E;
    localparam logic [7:0] ASCII_TLD = 8'h7E;
    localparam logic [7:0] ASCII_DEL = 8'h7F;

    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_CHAR,
        JOB_RUB,
        JOB_PROMPT,
        JOB_READ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       ready;
        logic [6:0] length;
        logic [7:0] read_char;
    } t_job;

    // CR CR LF '>' ' '
    function automatic logic [7:0] prompt_byte(input logic [2:0] step);
        logic [7:0] b;
        unique case (step)
            3'd0, 3'd1: b = ASCII_CR;
            3'd2:       b = ASCII_LF;
            3'd3:       b = ASCII_GT;
            default:    b = ASCII_SP;
        endcase
        return b;
    endfunction

    // BS ' ' BS
    function automatic logic [7:0] rub_byte(input logic [2:0] step);
        return (step == 3'd1) ? ASCII_SP : ASCII_BS;
    endfunction

endpackage

// File: hdl/cle_ram.sv
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cle_front.sv
`timescale 1ns / 1ps

module cle_front
    import cle_pkg::*;
#(
    parameter int LINE_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [6:0]  i_read_index,
    input  logic [2:0]  i_q_level,
    output logic        o_full,
    output logic        o_job_valid,
    output t_job        o_job
);

    localparam int CW = $clog2(LINE_BYTES);
    localparam logic [CW-1:0] MAX_CHARS = CW'(LINE_BYTES - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ready, n_ready;
    logic          r_s1_valid;
    t_job          r_s1_job, n_job;
    logic          r_s1_hit;

    logic          wr_en;
    logic [CW+6:0] idx_wide, cnt_wide;
    logic          rd_hit;
    logic [7:0]    ram_q;

    assign idx_wide = {{CW{1'b0}}, i_read_index};
    assign cnt_wide = {7'b0, r_count};
    assign rd_hit   = idx_wide < cnt_wide;

    always_comb begin
        logic [CW+6:0] len_wide;
        n_count   = r_count;
        n_ready   = r_ready;
        wr_en     = 1'b0;
        n_job     = '0;
        n_job.kind = JOB_NONE;
        unique case (i_func)
            FUNC_RX: begin
                priority if (r_ready) begin
                    n_job.kind = JOB_NONE;
                end else if (i_rx_byte == ASCII_CR || i_rx_byte == ASCII_LF) begin
                    if (r_count != '0) begin
                        n_ready = 1'b1;
                    end else begin
                        n_job.kind = JOB_PROMPT;
                    end
                end else if (i_rx_byte == ASCII_BS || i_rx_byte == ASCII_DEL) begin
                    if (r_count != '0) begin
                        n_count    = r_count - 1'b1;
                        n_job.kind = JOB_RUB;
                    end
                end else if (i_rx_byte >= ASCII_SP && i_rx_byte <= ASCII_TLD
                             && r_count < MAX_CHARS) begin
                    wr_en      = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_job.kind = JOB_CHAR;
                    n_job.ch   = i_rx_byte;
                end else begin
                    n_job.kind = JOB_NONE;
                end
            end
            FUNC_RELEASE: begin
                n_count = '0;
                n_ready = 1'b0;
            end
            FUNC_READ: begin
                n_job.kind = JOB_READ;
            end
            FUNC_NONE: begin
                n_job.kind = JOB_NONE;
            end
            default: begin
                n_job.kind = JOB_NONE;
            end
        endcase
        len_wide     = {7'b0, n_count};
        n_job.ready  = n_ready;
        n_job.length = len_wide[6:0];
    end

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_accept && wr_en),
        .i_waddr (r_count),
        .i_wdata (i_rx_byte),
        .i_raddr (idx_wide[CW-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ready    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_count <= n_count;
                r_ready <= n_ready;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_job <= n_job;
            r_s1_hit <= rd_hit && (i_func == FUNC_READ);
        end
    end

    // store data arrives in the cycle after the read is issued
    always_comb begin
        o_job           = r_s1_job;
        o_job.read_char = r_s1_hit ? ram_q : 8'h00;
    end

    assign o_job_valid = r_s1_valid;
    assign o_full = ({1'b0, i_q_level} + {3'b0, r_s1_valid}) >= 4'(QDEPTH);

endmodule

// File: hdl/cle_queue.sv
`timescale 1ns / 1ps

module cle_queue
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_job       i_job,
    input  logic       i_rd,
    output t_job       o_head,
    output logic       o_nonempty,
    output logic [2:0] o_level
);

    t_job           r_slot [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [2:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_level <= r_level + {2'b0, i_wr} - {2'b0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    assign o_head     = r_slot[r_rptr];
    assign o_nonempty = (r_level != '0);
    assign o_level    = r_level;

endmodule

// File: hdl/cle_back.sv
`timescale 1ns / 1ps

module cle_back
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_nonempty,
    output logic       o_deq,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_echo_byte,
    output logic       o_echo_valid,
    output logic       o_last,
    output logic       o_line_ready,
    output logic [6:0] o_line_length,
    output logic [7:0] o_read_char
);

    logic [2:0] r_step;
    logic       r_out_valid;
    logic       load;
    logic [2:0] final_step;
    logic       is_final;
    logic [7:0] byte_c;
    logic       evalid_c;

    assign load = i_nonempty && (!r_out_valid || i_pop);

    always_comb begin
        unique case (i_head.kind)
            JOB_CHAR: begin
                final_step = 3'd0;
                byte_c     = i_head.ch;
                evalid_c   = 1'b1;
            end
            JOB_RUB: begin
                final_step = 3'd2;
                byte_c     = rub_byte(r_step);
                evalid_c   = 1'b1;
            end
            JOB_PROMPT: begin
                final_step = 3'd4;
                byte_c     = prompt_byte(r_step);
                evalid_c   = 1'b1;
            end
            default: begin
                final_step = 3'd0;
                byte_c     = 8'h00;
                evalid_c   = 1'b0;
            end
        endcase
    end

    assign is_final = (r_step == final_step);
    assign o_deq    = load && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= is_final ? 3'd0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_echo_byte   <= byte_c;
            o_echo_valid  <= evalid_c;
            o_last        <= is_final;
            o_line_ready  <= i_head.ready;
            o_line_length <= i_head.length;
            o_read_char   <= i_head.read_char;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

// File: hdl/console_line_editor_echo_top.sv
`timescale 1ns / 1ps

// Console line editor with echo.
// Input queue: drive i_func / i_rx_byte / i_read_index with push; a beat is
// taken on a clock edge with push high and full low. func 0 feeds a received
// byte, func 1 releases the finished line, func 2 reads one held character.
// Result queue: while empty is low the oldest result sits on the o_ ports;
// pop takes it. Each input beat yields one result, or one per echo byte
// (1, 3 or 5), the final one flagged by o_last; line_ready, line_length and
// read_char report state after that input beat.
// A result passes through the front register and store read, the job queue
// and the output register before it reaches the output.
// Throughput: one result per cycle from the back end while pop keeps up, and
// an item has 1 to 5 results; the 4-entry job queue lets new input beats come
// in every cycle while a multi-byte echo drains, until the queue fills.
// Reset (synchronous, active low) empties the queues and clears the count
// and ready flag; the line store itself is not cleared.
// If the receiver holds pop low, the output holds, the job queue fills and
// full rises, stalling the sender without losing beats.
module console_line_editor_echo_top
    import cle_pkg::*;
#(
    parameter int LINE_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [6:0] i_read_index,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_echo_byte,
    output logic       o_echo_valid,
    output logic       o_last,
    output logic       o_line_ready,
    output logic [6:0] o_line_length,
    output logic [7:0] o_read_char
);

    logic       accept;
    logic       job_valid;
    t_job       job;
    t_job       head;
    logic       q_nonempty;
    logic [2:0] q_level;
    logic       deq;

    assign accept = push && !full;

    // front: classify, update count/flag, write or read the store
    cle_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .i_q_level    (q_level),
        .o_full       (full),
        .o_job_valid  (job_valid),
        .o_job        (job)
    );

    cle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (job_valid),
        .i_job      (job),
        .i_rd       (deq),
        .o_head     (head),
        .o_nonempty (q_nonempty),
        .o_level    (q_level)
    );

    // back: expand each job into its echo beats
    cle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_nonempty    (q_nonempty),
        .o_deq         (deq),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_echo_byte   (o_echo_byte),
        .o_echo_valid  (o_echo_valid),
        .o_last        (o_last),
        .o_line_ready  (o_line_ready),
        .o_line_length (o_line_length),
        .o_read_char   (o_read_char)
    );

endmodule

// File: hdl/cle_checker.sv
`timescale 1ns / 1ps

module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_echo_byte,
    input logic       o_echo_valid,
    input logic       o_last,
    input logic       o_line_ready,
    input logic [7:0] o_read_char
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_echo_byte) && $stable(o_last))
        else $error("stalled result changed");

    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_echo_valid |-> o_echo_byte == 8'h00 && o_last)
        else $error("non-echo result not a single zero beat");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_read_char != 8'h00 |-> !o_echo_valid)
        else $error("read data on an echo beat");

    a_no_echo_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_echo_valid |-> !o_line_ready)
        else $error("echo while a line is pending");

endmodule

bind console_line_editor_echo_top cle_checker u_cle_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

// Line editor testbench: every input beat goes through a behavioral model of the
// editor (line buffer, held count, line-done flag). The model queues the echo
// beats that the beat should produce. A monitor pops result beats from the DUT
// and compares each one, field by field, with the oldest queued beat.
module tb_top;
    import cle_pkg::*;

    localparam int LINE_BYTES   = 128;
    localparam int LINE_MAX     = LINE_BYTES - 1;   // most characters one line holds
    localparam int CYCLE_LIMIT  = 60000;            // watchdog limit on the whole run
    localparam int HOLD_CYCLES  = 200;              // receiver hold-off under backpressure
    localparam int DRAIN_CYCLES = 12;               // extra wait once no beats are expected
    localparam int IDLE_PCT     = 6;

    // one result beat as seen on the o_ ports
    typedef struct packed {
        logic [7:0] echo_byte;
        logic       echo_valid;
        logic       last;
        logic       line_ready;
        logic [6:0] line_length;
        logic [7:0] read_char;
    } t_echo_beat;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       push         = 1'b0;
    logic       pop          = 1'b0;
    logic [1:0] i_func       = FUNC_RX;
    logic [7:0] i_rx_byte    = 8'h00;
    logic [6:0] i_read_index = 7'd0;
    logic       full;
    logic       empty;
    logic [7:0] o_echo_byte;
    logic       o_echo_valid;
    logic       o_last;
    logic       o_line_ready;
    logic [6:0] o_line_length;
    logic [7:0] o_read_char;

    // model state: mirrors the editor after every accepted beat
    logic [7:0] line_chars [LINE_BYTES];
    logic [6:0] held_count = 7'd0;
    logic       line_done  = 1'b0;

    t_echo_beat pending_echo [$];

    // idle / stall controls, flipped by the tests
    bit sender_gaps = 1'b1;
    bit reader_gaps = 1'b1;
    bit hold_req    = 1'b0;
    logic hold_active = 1'b0;

    int error_count   = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int stall_cycles  = 0;
    int prompts_seen  = 0;
    int lines_done    = 0;

    console_line_editor_echo_top #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .empty        (empty),
        .pop          (pop),
        .o_echo_byte  (o_echo_byte),
        .o_echo_valid (o_echo_valid),
        .o_last       (o_last),
        .o_line_ready (o_line_ready),
        .o_line_length(o_line_length),
        .o_read_char  (o_read_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Editor model. Runs once per accepted input beat and queues the
    // result beats it should cause: one per echo byte, or a single status
    // beat when nothing is echoed.
    // ------------------------------------------------------------------
    function automatic void predict_edit(input logic [1:0] func, input logic [7:0] rx_byte,
                                         input logic [6:0] read_index);
        logic [7:0] echo_seq [5];
        int         n_echo;
        logic [7:0] rd;
        t_echo_beat beat;
        n_echo = 0;
        rd     = 8'h00;
        case (func)
            FUNC_RX: begin
                if (line_done) begin
                    // a finished line is waiting: byte dropped silently
                end else if (rx_byte == ASCII_CR || rx_byte == ASCII_LF) begin
                    if (held_count != 0) begin
                        line_done = 1'b1;
                        lines_done++;
                    end else begin
                        // empty line: fresh prompt, LF expanded to CR LF
                        echo_seq[0] = ASCII_CR;
                        echo_seq[1] = ASCII_CR;
                        echo_seq[2] = ASCII_LF;
                        echo_seq[3] = ASCII_GT;
                        echo_seq[4] = ASCII_SP;
                        n_echo = 5;
                        prompts_seen++;
                    end
                end else if (rx_byte == ASCII_BS || rx_byte == ASCII_DEL) begin
                    // rubout only when something is held
                    if (held_count != 0) begin
                        held_count  = held_count - 7'd1;
                        echo_seq[0] = ASCII_BS;
                        echo_seq[1] = ASCII_SP;
                        echo_seq[2] = ASCII_BS;
                        n_echo = 3;
                    end
                end else if (rx_byte >= ASCII_SP && rx_byte <= ASCII_TLD
                             && held_count < LINE_MAX) begin
                    line_chars[held_count] = rx_byte;
                    held_count  = held_count + 7'd1;
                    echo_seq[0] = rx_byte;
                    n_echo = 1;
                end
                // other control bytes and overflow are dropped without echo
            end
            FUNC_RELEASE: begin
                // clears even when no line was pending
                foreach (line_chars[k]) line_chars[k] = 8'h00;
                held_count = 7'd0;
                line_done  = 1'b0;
            end
            FUNC_READ: begin
                if (read_index < held_count) rd = line_chars[read_index];
            end
            default: begin
                // undefined selector: state untouched
            end
        endcase

        beat.line_ready  = line_done;
        beat.line_length = held_count;
        if (n_echo == 0) begin
            beat.echo_byte  = 8'h00;
            beat.echo_valid = 1'b0;
            beat.last       = 1'b1;
            beat.read_char  = rd;
            pending_echo.push_back(beat);
        end else begin
            for (int k = 0; k < n_echo; k++) begin
                beat.echo_byte  = echo_seq[k];
                beat.echo_valid = 1'b1;
                beat.last       = (k == n_echo - 1);
                beat.read_char  = 8'h00;
                pending_echo.push_back(beat);
            end
        end
    endfunction

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(ASCII_TLD, ASCII_SP));
    endfunction

    // read position biased toward the held characters and just past them
    function automatic logic [6:0] near_index();
        if ($urandom_range(99) < 20) return 7'($urandom);
        return 7'($urandom_range(int'(held_count) + 1, 0));
    endfunction

    // ------------------------------------------------------------------
    // Input side. Holds the beat until accepted (push high, full low at
    // the edge), then runs the model. push stays high between back-to-back
    // beats; it only drops in an idle gap or at the very end.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] func, input logic [7:0] rx_byte,
                             input logic [6:0] read_index);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_func       <= func;
        i_rx_byte    <= rx_byte;
        i_read_index <= read_index;
        @(posedge i_clk);
        while (full) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        items_sent++;
        predict_edit(func, rx_byte, read_index);
    endtask

    // ------------------------------------------------------------------
    // Output side: pop with random stalls; a hold-off request keeps pop
    // low for a long stretch, counted in the process below.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_active) begin
            pop <= 1'b0;
        end else begin
            pop <= !(reader_gaps && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin : receiver_holdoff
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("  mismatch on %s at result beat %0d: got 0x%0h, want 0x%0h",
                 what, beats_checked, got, want);
        error_count++;
    endtask

    // every popped result beat is checked against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_echo_beat want;
        if (i_rst_n && pop && !empty) begin
            if (pending_echo.size() == 0) begin
                report_mismatch("unexpected beat", o_echo_byte, 0);
            end else begin
                want = pending_echo.pop_front();
                if (o_echo_byte !== want.echo_byte)
                    report_mismatch("echo_byte", o_echo_byte, want.echo_byte);
                if (o_echo_valid !== want.echo_valid)
                    report_mismatch("echo_valid", o_echo_valid, want.echo_valid);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
                if (o_line_ready !== want.line_ready)
                    report_mismatch("line_ready", o_line_ready, want.line_ready);
                if (o_line_length !== want.line_length)
                    report_mismatch("line_length", o_line_length, want.line_length);
                if (o_read_char !== want.read_char)
                    report_mismatch("read_char", o_read_char, want.read_char);
            end
            beats_checked++;
        end
    end

    // watchdog: nothing after the $finish in this process
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycle_count, pending_echo.size());
        $display("[console_line_editor_echo_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked beats: empty-line prompt on CR and LF, rubout on an empty
    // line, control bytes, printable extremes, reads inside and past the
    // line, undefined selector, bytes while a line waits, double release.
    task automatic test_directed();
        send_item(FUNC_READ,    8'hFF,     7'd0);
        send_item(FUNC_READ,    8'h00,     7'd127);
        send_item(FUNC_RX,      ASCII_BS,  7'd0);
        send_item(FUNC_RX,      ASCII_DEL, 7'd127);
        send_item(FUNC_RX,      ASCII_CR,  7'd0);
        send_item(FUNC_RX,      ASCII_LF,  7'd0);
        send_item(FUNC_RX,      8'h00,     7'd0);
        send_item(FUNC_RX,      8'h1F,     7'd0);
        send_item(FUNC_RX,      8'h80,     7'd0);
        send_item(FUNC_RX,      8'hFF,     7'd0);
        send_item(FUNC_RX,      ASCII_SP,  7'd0);
        send_item(FUNC_RX,      ASCII_TLD, 7'd0);
        send_item(FUNC_RX,      8'h41,     7'd0);
        send_item(FUNC_READ,    8'h00,     7'd0);
        send_item(FUNC_READ,    8'h00,     7'd2);
        send_item(FUNC_READ,    8'h00,     7'd3);
        send_item(FUNC_RX,      ASCII_DEL, 7'd0);
        send_item(FUNC_NONE,    8'hFF,     7'd127);
        send_item(FUNC_RX,      ASCII_CR,  7'd0);
        send_item(FUNC_RX,      8'h78,     7'd0);   // ignored: line pending
        send_item(FUNC_RX,      ASCII_BS,  7'd0);   // ignored: line pending
        send_item(FUNC_READ,    8'h00,     7'd1);
        send_item(FUNC_RELEASE, 8'hFF,     7'd127);
        send_item(FUNC_RELEASE, 8'h00,     7'd0);   // nothing pending
        send_item(FUNC_RX,      ASCII_BS,  7'd0);   // count back at zero
    endtask

    // Fill the line to its limit, push past it, read the top positions,
    // rub out and refill, then finish and release.
    task automatic test_full_line();
        for (int k = 0; k < LINE_MAX + 3; k++)
            send_item(FUNC_RX, printable_byte(), 7'($urandom));
        send_item(FUNC_READ, 8'($urandom), 7'(LINE_MAX - 1));
        send_item(FUNC_READ, 8'($urandom), 7'(LINE_MAX));
        send_item(FUNC_READ, 8'($urandom), 7'($urandom));
        send_item(FUNC_RX, ASCII_DEL, 7'($urandom));
        send_item(FUNC_RX, printable_byte(), 7'($urandom));
        send_item(FUNC_RX, printable_byte(), 7'($urandom));   // full again: dropped
        send_item(FUNC_RX, ASCII_LF, 7'($urandom));
        send_item(FUNC_RELEASE, 8'($urandom), 7'($urandom));
    endtask

    // Receiver holds off while the sender keeps offering prompt requests
    // (five echo beats each), so the job queue fills and full backs up.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        hold_req    = 1'b1;
        repeat (30)
            send_item(FUNC_RX, ($urandom_range(1) != 0) ? ASCII_CR : ASCII_LF,
                      7'($urandom));
        sender_gaps = 1'b1;
    endtask

    // One typing session: characters with some rubouts and stray control
    // bytes, a few reads, end of line, bytes while it waits, release.
    task automatic type_session();
        int         n_keys;
        int         pick;
        logic [7:0] b;
        n_keys = $urandom_range(14, 0);
        for (int k = 0; k < n_keys; k++) begin
            pick = $urandom_range(99);
            if (pick < 10)
                b = ($urandom_range(1) != 0) ? ASCII_BS : ASCII_DEL;
            else if (pick < 14)
                b = 8'($urandom);
            else
                b = printable_byte();
            send_item(FUNC_RX, b, 7'($urandom));
        end
        if ($urandom_range(99) < 10) begin
            // abandon the line without ending it
            send_item(FUNC_RELEASE, 8'($urandom), 7'($urandom));
        end else begin
            repeat ($urandom_range(3)) send_item(FUNC_READ, 8'($urandom), near_index());
            send_item(FUNC_RX, ($urandom_range(1) != 0) ? ASCII_CR : ASCII_LF,
                      7'($urandom));
            repeat ($urandom_range(2)) send_item(FUNC_RX, 8'($urandom), 7'($urandom));
            send_item(FUNC_READ, 8'($urandom), near_index());
            send_item(FUNC_RELEASE, 8'($urandom), 7'($urandom));
        end
    endtask

    task automatic test_sessions(input int until_items);
        int third;
        third = (until_items - items_sent) / 3;
        while (items_sent < until_items) begin
            // middle stretch runs with no idling on either side
            sender_gaps = !(items_sent >= until_items - 2 * third
                            && items_sent < until_items - third);
            reader_gaps = sender_gaps;
            type_session();
        end
        sender_gaps = 1'b1;
        reader_gaps = 1'b1;
    endtask

    // Anything goes, undefined selector included.
    task automatic test_noise(input int n_items);
        repeat (n_items) send_item(2'($urandom), 8'($urandom), 7'($urandom));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_echo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        foreach (line_chars[k]) line_chars[k] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_line();
        test_backpressure();
        test_sessions(390);
        test_noise(40);
        drain_results();

        $display("%0d input beats, %0d result beats checked: %0d prompts, %0d finished lines",
                 items_sent, beats_checked, prompts_seen, lines_done);
        $display("line filled to %0d chars; input stalled %0d cycles under backpressure",
                 LINE_MAX, stall_cycles);
        if (error_count == 0)
            $display("[console_line_editor_echo_top] OK");
        else
            $display("[console_line_editor_echo_top] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/cle_front.sv
hdl/cle_queue.sv
hdl/cle_back.sv
hdl/console_line_editor_echo_top.sv
hdl/cle_checker.sv
sim/tb_top.sv
